// ----- rtl/vn_pkg.sv -----
package vn_pkg;

    localparam int unsigned COMP_W        = 32;
    localparam int unsigned SUM_W         = 2 * COMP_W;
    localparam int unsigned ROOT_W        = SUM_W / 2;
    localparam int unsigned OUT_FRAC_BITS = 30;
    localparam int unsigned QUO_W         = OUT_FRAC_BITS + 1;

    // pipeline depths
    localparam int unsigned LAT_SQRT = ROOT_W;
    localparam int unsigned LAT_DIV  = QUO_W;
    localparam int unsigned LAT_PRE  = 3;
    localparam int unsigned LAT_ALL  = LAT_PRE + LAT_SQRT + LAT_DIV + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic                     zero_length;
    } t_vec_out;

    typedef struct packed {
        logic [2:0][COMP_W-1:0] mag;
        logic [2:0]             neg;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_sign;

endpackage

// ----- rtl/vn_sqrt.sv -----
module vn_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [vn_pkg::SUM_W-1:0]        i_op,
    output logic [vn_pkg::ROOT_W-1:0]       o_root
);

    localparam int unsigned N     = vn_pkg::LAT_SQRT;
    localparam int unsigned SW    = vn_pkg::SUM_W;
    localparam int unsigned RW    = vn_pkg::ROOT_W;
    localparam int unsigned REM_W = RW + 2;

    logic [REM_W-1:0] r_rem  [N];
    logic [RW-1:0]    r_root [N];
    logic [SW-1:0]    r_op   [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic [REM_W-1:0] rem_in;
            logic [RW-1:0]    root_in;
            logic [SW-1:0]    op_in;
            logic [REM_W+1:0] acc;
            logic [REM_W+1:0] trial;
            logic [REM_W-1:0] n_rem;
            logic [RW-1:0]    n_root;

            if (g == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign op_in   = i_op;
            end else begin : g_next
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
                assign op_in   = r_op[g-1];
            end

            always_comb begin
                // bring down the next two bits, try root*4+1
                acc   = {rem_in, op_in[SW-1:SW-2]};
                trial = {2'b00, root_in, 2'b01};
                if (acc >= trial) begin
                    n_rem  = REM_W'(acc - trial);
                    n_root = {root_in[RW-2:0], 1'b1};
                end else begin
                    n_rem  = acc[REM_W-1:0];
                    n_root = {root_in[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= n_rem;
                    r_root[g] <= n_root;
                    r_op[g]   <= {op_in[SW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[N-1];

endmodule

// ----- rtl/vn_div.sv -----
module vn_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vn_pkg::COMP_W-1:0]   i_num,
    input  logic [vn_pkg::ROOT_W-1:0]   i_den,
    output logic [vn_pkg::QUO_W-1:0]    o_quo
);

    localparam int unsigned N  = vn_pkg::LAT_DIV;
    localparam int unsigned DW = vn_pkg::ROOT_W;
    localparam int unsigned NW = vn_pkg::COMP_W;
    localparam int unsigned QW = vn_pkg::QUO_W;

    // numerator never exceeds the denominator, so the remainder fits DW bits
    logic [DW-1:0] r_rem [N];
    logic [DW-1:0] r_den [N];
    logic [QW-1:0] r_quo [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic [DW:0]   part;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic          take;

            if (g == 0) begin : g_first
                assign part   = (DW + 1)'(i_num);
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign part   = {r_rem[g-1], 1'b0};
                assign den_in = r_den[g-1];
                assign quo_in = r_quo[g-1];
            end

            assign take = (part >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= take ? DW'(part - {1'b0, den_in}) : part[DW-1:0];
                    r_den[g] <= den_in;
                    r_quo[g] <= {quo_in[QW-2:0], take};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[N-1];

endmodule

// ----- rtl/vector3_normalize_top.sv -----
// Vector normalizer: scales a signed Q16.16 3D vector to unit length in Q1.30.
//
// Request channel: i_valid / o_stall with payload i_req (vec_x, vec_y, vec_z).
// Result channel:  o_valid / i_stall with payload o_res (unit_x, unit_y,
// unit_z, zero_length). A request is taken on a rising edge with valid high
// and stall low.
//
// Throughput is one vector per cycle while the receiver does not stall. From
// request to result the stages are: magnitudes, squares and the sum of squares;
// the square root (one result bit per stage); the three parallel dividers (one
// quotient bit per stage); and one output register.
//
// A zero vector gives zero components with zero_length set.
// Reset (synchronous, active low) clears all valid bits; data in flight is lost.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises; bubbles further up are not squeezed out.
module vector3_normalize_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  vn_pkg::t_vec_in  i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output vn_pkg::t_vec_out o_res
);

    localparam int unsigned CW  = vn_pkg::COMP_W;
    localparam int unsigned SW  = vn_pkg::SUM_W;
    localparam int unsigned RW  = vn_pkg::ROOT_W;
    localparam int unsigned QW  = vn_pkg::QUO_W;
    localparam int unsigned LS  = vn_pkg::LAT_SQRT;
    localparam int unsigned LD  = vn_pkg::LAT_DIV;
    localparam int unsigned LA  = vn_pkg::LAT_ALL;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << vn_pkg::OUT_FRAC_BITS;

    logic          en;
    logic [LA-1:0] r_vld;

    vn_pkg::t_side          r_s1, r_s2, r_s3;
    logic [2:0][SW-1:0]     r_sq;
    logic [SW-1:0]          r_sum;
    vn_pkg::t_side          r_dl [LS];
    vn_pkg::t_sign          r_sg [LD];
    logic [RW-1:0]          root;
    logic [2:0][QW-1:0]     quo;
    vn_pkg::t_sign          sg_in;
    vn_pkg::t_vec_out       r_out;
    logic [2:0][CW-1:0]     comp;

    // hold everything while a finished result is refused
    assign en      = !(r_vld[LA-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LA-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.neg[2] <= i_req.vec_x[CW-1];
            r_s1.neg[1] <= i_req.vec_y[CW-1];
            r_s1.neg[0] <= i_req.vec_z[CW-1];
            r_s1.mag[2] <= i_req.vec_x[CW-1] ? CW'(-i_req.vec_x) : i_req.vec_x;
            r_s1.mag[1] <= i_req.vec_y[CW-1] ? CW'(-i_req.vec_y) : i_req.vec_y;
            r_s1.mag[0] <= i_req.vec_z[CW-1] ? CW'(-i_req.vec_z) : i_req.vec_z;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SW'(r_s1.mag[k]) * SW'(r_s1.mag[k]);
            end
            r_s2  <= r_s1;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_s3  <= r_s2;
            r_dl[0] <= r_s3;
            for (int k = 1; k < LS; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
            r_sg[0] <= sg_in;
            for (int k = 1; k < LD; k++) begin
                r_sg[k] <= r_sg[k-1];
            end
        end
    end

    vn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_op   (r_sum),
        .o_root (root)
    );

    always_comb begin
        sg_in.neg  = r_dl[LS-1].neg;
        sg_in.zero = (root == '0);
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            vn_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_dl[LS-1].mag[g]),
                .i_den (root),
                .o_quo (quo[g])
            );

            always_comb begin
                logic [QW-1:0] q;
                q = (quo[g] > ONE_Q) ? ONE_Q : quo[g];
                if (r_sg[LD-1].zero) begin
                    comp[g] = '0;
                end else if (r_sg[LD-1].neg[g]) begin
                    comp[g] = CW'(-CW'(q));
                end else begin
                    comp[g] = CW'(q);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.unit_x      <= comp[2];
            r_out.unit_y      <= comp[1];
            r_out.unit_z      <= comp[0];
            r_out.zero_length <= r_sg[LD-1].zero;
        end
    end

    assign o_valid = r_vld[LA-1];
    assign o_res   = r_out;

endmodule

// ----- test/vector3_normalize_top_test.sv -----
`timescale 1ns / 100ps

module vector3_normalize_top_test;

    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_MAX  = 400000;
    localparam int HOLD_LONG  = 300;

    typedef struct {
        vn_pkg::t_vec_in  req;
        bit               known;
        vn_pkg::t_vec_out res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    vn_pkg::t_vec_in  i_req;
    logic             o_valid;
    logic             i_stall;
    vn_pkg::t_vec_out o_res;

    vn_pkg::t_vec_out unit_queue[$];
    t_row     rows[$];
    int       mismatch_cnt;
    int       result_cnt;
    int       zero_cnt;
    int       sat_cnt;
    int       cycle_cnt;
    bit       rx_hold;
    bit       rx_calm;
    bit       tx_calm;

    vector3_normalize_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt64(logic [63:0] op);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= op) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_comp(logic [31:0] v, logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] quo;
        mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        quo = (mag << vn_pkg::OUT_FRAC_BITS) / len;
        if (quo > (64'd1 << vn_pkg::OUT_FRAC_BITS)) begin
            quo = 64'd1 << vn_pkg::OUT_FRAC_BITS;
        end
        if (v[31]) begin
            quo = -quo;
        end
        return quo[31:0];
    endfunction

    function automatic vn_pkg::t_vec_out normalize(vn_pkg::t_vec_in v);
        vn_pkg::t_vec_out r;
        logic [63:0] mx, my, mz, len;
        mx = v.vec_x[31] ? 64'h1_0000_0000 - {32'd0, v.vec_x} : {32'd0, v.vec_x};
        my = v.vec_y[31] ? 64'h1_0000_0000 - {32'd0, v.vec_y} : {32'd0, v.vec_y};
        mz = v.vec_z[31] ? 64'h1_0000_0000 - {32'd0, v.vec_z} : {32'd0, v.vec_z};
        len = isqrt64(mx * mx + my * my + mz * mz);
        r = '0;
        if (len == 0) begin
            r.zero_length = 1'b1;
        end else begin
            r.unit_x = unit_comp(v.vec_x, len);
            r.unit_y = unit_comp(v.vec_y, len);
            r.unit_z = unit_comp(v.vec_z, len);
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) - 1;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2: return $urandom_range(0, 65535) - 32768;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit known, vn_pkg::t_vec_out res);
        t_row r;
        r.req = '{x, y, z};
        r.known = known;
        r.res = res;
        rows.push_back(r);
    endtask

    task automatic send(vn_pkg::t_vec_in v);
        i_req <= v;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        unit_queue.push_back(normalize(v));
        @(negedge i_clk);
        if (!tx_calm && $urandom_range(0, 99) < 21) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
    endtask

    // receiver stall pattern, with one long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_stall <= 1'b1;
                repeat (HOLD_LONG) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            i_stall <= !rx_calm && ($urandom_range(0, 99) < 21);
        end
    end

    // check results against the oldest prediction
    always @(posedge i_clk) begin
        vn_pkg::t_vec_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (unit_queue.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %h", o_res);
            end else begin
                want = unit_queue.pop_front();
                result_cnt++;
                if (want.zero_length) zero_cnt++;
                if (want.unit_x == 32'h4000_0000 || want.unit_x == 32'hc000_0000)
                    sat_cnt++;
                if (o_res.unit_x !== want.unit_x || o_res.unit_y !== want.unit_y ||
                    o_res.unit_z !== want.unit_z ||
                    o_res.zero_length !== want.zero_length) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: want %h %h %h %b got %h %h %h %b",
                                 want.unit_x, want.unit_y, want.unit_z,
                                 want.zero_length, o_res.unit_x, o_res.unit_y,
                                 o_res.unit_z, o_res.zero_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("vector3_normalize_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        vn_pkg::t_vec_out z0, px, nx;
        vn_pkg::t_vec_in v;
        cycle_cnt = 0;
        mismatch_cnt = 0;
        result_cnt = 0;
        zero_cnt = 0;
        sat_cnt = 0;
        rx_hold = 0;
        rx_calm = 0;
        tx_calm = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        z0 = '0;
        z0.zero_length = 1'b1;
        px = '0;
        px.unit_x = 32'h4000_0000;
        nx = '0;
        nx.unit_x = 32'hc000_0000;
        add_row(0, 0, 0, 1, z0);
        add_row(32'h0001_0000, 0, 0, 1, px);
        add_row(32'hffff_0000, 0, 0, 1, nx);
        add_row(1, 0, 0, 1, px);
        add_row(32'hffff_ffff, 0, 0, 1, nx);
        add_row(32'h8000_0000, 0, 0, 1, nx);
        add_row(32'h7fff_ffff, 0, 0, 1, px);
        add_row(0, 32'h8000_0000, 0, 0, z0);
        add_row(0, 0, 32'h7fff_ffff, 0, z0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, z0);
        add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, z0);
        add_row(1, 1, 1, 0, z0);
        add_row(1, 1, 0, 0, z0);
        add_row(3, 4, 0, 0, z0);
        add_row(32'hffff_fffd, 32'hffff_fffc, 32'h0000_000c, 0, z0);
        add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 0, z0);
        foreach (rows[i]) begin
            if (rows[i].known && normalize(rows[i].req) != rows[i].res) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("table row %0d disagrees with prediction", i);
            end
            send(rows[i].req);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // calm stretch, then a long receiver hold-off, then a drain pause
            rx_calm = (n >= 400 && n < 700);
            tx_calm = rx_calm;
            if (n == 1000) rx_hold = 1;
            if (n == 1500) begin
                i_valid <= 1'b0;
                while (unit_queue.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            v.vec_x = rand_comp();
            v.vec_y = rand_comp();
            v.vec_z = rand_comp();
            send(v);
        end
        i_valid <= 1'b0;
        while (unit_queue.size() != 0) @(posedge i_clk);
        repeat (vn_pkg::LAT_ALL + 10) @(posedge i_clk);

        $display("checked %0d normalized vectors: %0d zero-length, %0d saturated on x",
                 result_cnt, zero_cnt, sat_cnt);
        if (mismatch_cnt == 0) begin
            $display("vector3_normalize_top_test: PASS");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("vector3_normalize_top_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vn_pkg.sv
rtl/vn_sqrt.sv
rtl/vn_div.sv
rtl/vector3_normalize_top.sv
test/vector3_normalize_top_test.sv
